@@ sv/rtc_pkg.sv @@
// Shared types, constants and codes of the RTD temperature classifier.
// No dependencies; every other file but rtc_if.sv imports this package.
package rtc_pkg;

  localparam int TEMP_LIMIT_C      = 800;
  localparam int ADC_FULL_SCALE_MV = 4096;
  localparam int TEMP_MAX_CENTI    = TEMP_LIMIT_C * 100;

  // converter code to microvolts: code * UV_SCALE / 2^15
  localparam logic [22:0] UV_SCALE = 23'(ADC_FULL_SCALE_MV * 1000);
  localparam int MIN_SENSOR_UV     = 10000;

  // Callendar-Van Dusen coefficients, A * 1e7 and |B| * 1e10
  localparam longint CVD_A      = 39083;
  localparam longint CVD_B      = 5775;
  localparam longint CVD_A2     = CVD_A * CVD_A;
  localparam longint CVD_4B     = 400 * CVD_B;
  localparam longint CVD_A_Q16  = CVD_A * 65536;

  // temperature scaling: T = floor((SCALE_MUL * x + SCALE_BIAS) / (CVD_B * 2^12))
  localparam longint SCALE_MUL  = 3125;
  localparam longint SCALE_BIAS = CVD_B * 2048;
  localparam int     SCALE_SHR  = 12;

  // datapath widths
  localparam int RES_DEN_W = 22;
  localparam int RES_Q_W   = 32;
  localparam int R0_W      = 14;
  localparam int DR_W      = 54;
  localparam int DR_NUM_W  = DR_W + 32;
  localparam int SQ_IN_W   = 64;
  localparam int SQ_W      = 32;

  // quotient clamp window, wide enough that the offset cannot pull a value back in
  localparam int     OFF_W   = 11;
  localparam int     OFF_SPAN = 2 ** (OFF_W - 1);
  localparam int     Q_LO    = -OFF_SPAN;
  localparam longint M_LO    = longint'(Q_LO) * CVD_B;
  localparam longint M_HI    = (longint'(TEMP_MAX_CENTI + OFF_SPAN) + 1) * CVD_B - 1;
  localparam int     MP_W    = $clog2(M_HI - M_LO + 1);
  localparam int     QE_W    = $clog2((M_HI - M_LO) / CVD_B + 1);
  localparam int     RECIP_SHIFT = 42;
  localparam longint RECIP_K = (longint'(1) << RECIP_SHIFT) / CVD_B;
  localparam int     RECIP_W = $clog2(RECIP_K + 1);

  // classification bounds, hundredths of a degree
  localparam int CLS_MODERATE = 2800;
  localparam int CLS_WARNING  = 5000;
  localparam int CLS_CRITICAL = 7200;
  localparam int CLS_HIGH     = 8000;
  localparam int CLS_VHIGH    = 10000;

  typedef enum logic [2:0] {
    CFG_SUPPLY = 3'd0,
    CFG_RFIX   = 3'd1,
    CFG_R0     = 3'd2,
    CFG_OFFSET = 3'd3,
    CFG_BDIV   = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    STS_LOW       = 3'd0,
    STS_MODERATE  = 3'd1,
    STS_WARNING   = 3'd2,
    STS_CRITICAL  = 3'd3,
    STS_HIGH      = 3'd4,
    STS_VERY_HIGH = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    SST_NORMAL     = 3'd0,
    SST_INCREASING = 3'd1,
    SST_CRITICAL   = 3'd2,
    SST_HIGH       = 3'd3,
    SST_VERY_HIGH  = 3'd4
  } state_t;

  typedef struct packed {
    logic [21:0]        supply;
    logic [19:0]        rfix;
    logic [R0_W-1:0]    r0;
    logic signed [10:0] offset;
    logic [4:0]         bdiv;
  } cfg_t;

  // data that rides along the cell chains
  typedef struct packed {
    logic signed [22:0] suv;
    logic signed [25:0] buv;
    logic               ok;
    logic               sat;
    logic [31:0]        rc;
  } side_t;

endpackage

@@ sv/rtc_if.sv @@
// Valid/ready channel interfaces of the RTD temperature classifier.
// Depends on nothing but the field widths of the block.
interface rtc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sensor_code;
  logic signed [15:0] battery_code;

  modport source (output valid, output sensor_code, output battery_code, input ready);
  modport sink   (input valid, input sensor_code, input battery_code, output ready);
endinterface

interface rtc_out_if;
  logic               valid;
  logic               ready;
  logic [16:0]        temperature_centi;
  logic [31:0]        resistance_centiohm;
  logic signed [22:0] sensor_microvolts;
  logic signed [25:0] battery_microvolts;
  logic [2:0]         status_code;
  logic [2:0]         state_code;
  logic               conversion_valid;

  modport source (output valid, output temperature_centi, output resistance_centiohm,
                  output sensor_microvolts, output battery_microvolts,
                  output status_code, output state_code, output conversion_valid,
                  input ready);
  modport sink   (input valid, input temperature_centi, input resistance_centiohm,
                  input sensor_microvolts, input battery_microvolts,
                  input status_code, input state_code, input conversion_valid,
                  output ready);
endinterface

@@ sv/rtc_div_cell.sv @@
// One restoring-division cell: shifts in one dividend bit, yields one quotient bit.
// Depends on rtc_pkg (side_t).
module rtc_div_cell import rtc_pkg::*; #(
  parameter int DW = 22,
  parameter int NW = 32,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_i,
  input  logic [DW-1:0] den_i,
  input  logic [DW-1:0] rem_i,
  input  logic [NW-1:0] num_i,
  input  logic [QW-1:0] q_i,
  input  side_t         side_i,
  output logic          v_o,
  output logic [DW-1:0] den_o,
  output logic [DW-1:0] rem_o,
  output logic [NW-1:0] num_o,
  output logic [QW-1:0] q_o,
  output side_t         side_o
);

  logic [DW:0]   trial;
  logic          ge;
  logic [DW-1:0] rem_nxt;
  logic          v_r;
  logic [DW-1:0] den_r, rem_r;
  logic [NW-1:0] num_r;
  logic [QW-1:0] q_r;
  side_t         side_r;

  assign trial   = {rem_i, num_i[NW-1]};
  assign ge      = trial >= {1'b0, den_i};
  assign rem_nxt = ge ? DW'(trial - {1'b0, den_i}) : trial[DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r  <= den_i;
      rem_r  <= rem_nxt;
      num_r  <= {num_i[NW-2:0], 1'b0};
      q_r    <= {q_i[QW-2:0], ge};
      side_r <= side_i;
    end
  end

  assign v_o    = v_r;
  assign den_o  = den_r;
  assign rem_o  = rem_r;
  assign num_o  = num_r;
  assign q_o    = q_r;
  assign side_o = side_r;

endmodule

@@ sv/rtc_sqrt_cell.sv @@
// One digit-by-digit square root cell: consumes two radicand bits, yields one root bit.
// Depends on rtc_pkg (side_t).
module rtc_sqrt_cell import rtc_pkg::*; #(
  parameter int RW = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            v_i,
  input  logic [2*RW-1:0] rad_i,
  input  logic [RW:0]     rem_i,
  input  logic [RW-1:0]   root_i,
  input  side_t           side_i,
  output logic            v_o,
  output logic [2*RW-1:0] rad_o,
  output logic [RW:0]     rem_o,
  output logic [RW-1:0]   root_o,
  output side_t           side_o
);

  logic [RW+2:0]   trial;
  logic [RW+1:0]   test;
  logic            ge;
  logic [RW:0]     rem_nxt;
  logic            v_r;
  logic [2*RW-1:0] rad_r;
  logic [RW:0]     rem_r;
  logic [RW-1:0]   root_r;
  side_t           side_r;

  assign trial   = {rem_i, rad_i[2*RW-1 -: 2]};
  assign test    = {root_i, 2'b01};
  assign ge      = trial >= {1'b0, test};
  assign rem_nxt = ge ? (RW+1)'(trial - {1'b0, test}) : trial[RW:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= {rad_i[2*RW-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= {root_i[RW-2:0], ge};
      side_r <= side_i;
    end
  end

  assign v_o    = v_r;
  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign side_o = side_r;

endmodule

@@ sv/rtc_front.sv @@
// Front stages: codes to microvolts, range check, divider numerator and denominator.
// Depends on rtc_pkg; feeds the resistance division chain.
module rtc_front import rtc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  cfg_t                 cfg,
  input  logic                 v_i,
  input  logic signed [15:0]   sensor_code,
  input  logic signed [15:0]   battery_code,
  output logic                 v_o,
  output logic [RES_DEN_W-1:0] den_o,
  output logic [RES_DEN_W-1:0] rem_o,
  output logic [RES_Q_W-1:0]   num_o,
  output side_t                side_o
);

  localparam logic signed [23:0] UvScaleS = 24'(UV_SCALE);
  localparam logic signed [23:0] MinUv    = 24'(MIN_SENSOR_UV);
  localparam logic signed [29:0] BuvMax   = 30'((1 <<< 25) - 1);
  localparam logic signed [29:0] BuvMin   = -30'(1 <<< 25);
  localparam logic signed [23:0] SuvMax   = 24'((1 <<< 22) - 1);
  localparam logic signed [23:0] SuvMin   = -24'(1 <<< 22);

  // stage 1: raw products
  logic signed [39:0] ps, pb;
  logic               s1_v_r;
  logic signed [39:0] s1_ps_r, s1_pb_r;

  // stage 2: truncated microvolts
  logic signed [39:0] ps_adj, pb_adj;
  logic               s2_v_r;
  logic signed [23:0] s2_suv_r, s2_buv_r;

  // stage 3: range check, scaled battery, resistor product
  logic signed [29:0]  buv_full;
  logic signed [25:0]  buv_cl;
  logic signed [22:0]  suv_cl;
  logic                ok;
  logic [RES_DEN_W-1:0] den;
  logic [41:0]         num;
  logic                s3_v_r;
  logic [41:0]         s3_num_r;
  logic [RES_DEN_W-1:0] s3_den_r;
  side_t               s3_side_r;

  // stage 4: rounding bias and saturation test
  logic [49:0]          numr;
  logic [RES_DEN_W-1:0] hi;
  logic                 sat;
  side_t                side4;
  logic                 s4_v_r;
  logic [RES_DEN_W-1:0] s4_den_r, s4_rem_r;
  logic [RES_Q_W-1:0]   s4_num_r;
  side_t                s4_side_r;

  assign ps = sensor_code * UvScaleS;
  assign pb = battery_code * UvScaleS;

  // truncation toward zero on the divide by 2^15
  assign ps_adj = s1_ps_r + (s1_ps_r[39] ? 40'sd32767 : 40'sd0);
  assign pb_adj = s1_pb_r + (s1_pb_r[39] ? 40'sd32767 : 40'sd0);

  assign buv_full = s2_buv_r * signed'({1'b0, cfg.bdiv});

  always_comb begin
    if (buv_full > BuvMax) begin
      buv_cl = BuvMax[25:0];
    end else if (buv_full < BuvMin) begin
      buv_cl = BuvMin[25:0];
    end else begin
      buv_cl = buv_full[25:0];
    end
    if (s2_suv_r > SuvMax) begin
      suv_cl = SuvMax[22:0];
    end else if (s2_suv_r < SuvMin) begin
      suv_cl = SuvMin[22:0];
    end else begin
      suv_cl = s2_suv_r[22:0];
    end
  end

  assign ok  = (s2_suv_r > MinUv) && (s2_suv_r < signed'({2'b00, cfg.supply}))
               && (cfg.r0 != '0);
  assign den = cfg.supply - s2_suv_r[21:0];
  assign num = 42'(s2_suv_r[21:0]) * 42'(cfg.rfix);

  assign numr = 50'(s3_num_r) * 50'd100 + 50'(s3_den_r[RES_DEN_W-1:1]);
  assign hi   = RES_DEN_W'(numr[49:32]);
  assign sat  = hi >= s3_den_r;

  always_comb begin
    side4     = s3_side_r;
    side4.sat = sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= v_i;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ps_r       <= ps;
      s1_pb_r       <= pb;
      s2_suv_r      <= ps_adj[38:15];
      s2_buv_r      <= pb_adj[38:15];
      s3_num_r      <= num;
      s3_den_r      <= den;
      s3_side_r.suv <= suv_cl;
      s3_side_r.buv <= buv_cl;
      s3_side_r.ok  <= ok;
      s3_side_r.sat <= 1'b0;
      s3_side_r.rc  <= '0;
      s4_den_r      <= s3_den_r;
      s4_rem_r      <= sat ? '0 : hi;
      s4_num_r      <= numr[RES_Q_W-1:0];
      s4_side_r     <= side4;
    end
  end

  assign v_o    = s4_v_r;
  assign den_o  = s4_den_r;
  assign rem_o  = s4_rem_r;
  assign num_o  = s4_num_r;
  assign side_o = s4_side_r;

endmodule

@@ sv/rtc_mid.sv @@
// Middle stages: saturated resistance and scaled discriminant D * R0.
// Depends on rtc_pkg; sits between the two division chains.
module rtc_mid import rtc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  cfg_t                cfg,
  input  logic                v_i,
  input  logic [RES_Q_W-1:0]  q_i,
  input  side_t               side_i,
  output logic                v_o,
  output logic [R0_W-1:0]     den_o,
  output logic [DR_NUM_W-1:0] num_o,
  output side_t               side_o
);

  localparam logic signed [22:0] Cvd4bS = 23'(CVD_4B);

  logic [31:0]        rc;
  logic [20:0]        r0x100;
  logic signed [33:0] diff;
  logic [44:0]        p1;
  logic signed [56:0] p2;
  side_t              side1;
  logic               m1_v_r;
  logic [44:0]        m1_p1_r;
  logic signed [56:0] m1_p2_r;
  side_t              m1_side_r;

  logic signed [57:0] dr;
  side_t              side2;
  logic               m2_v_r;
  logic [DR_NUM_W-1:0] m2_num_r;
  side_t              m2_side_r;

  assign rc     = side_i.sat ? '1 : q_i;
  assign r0x100 = 21'(cfg.r0) * 21'd100;
  assign diff   = signed'(34'(rc)) - signed'(34'(r0x100));
  assign p1     = 45'(CVD_A2) * 45'(cfg.r0);
  assign p2     = diff * Cvd4bS;

  always_comb begin
    side1    = side_i;
    side1.rc = rc;
  end

  assign dr = signed'({13'b0, m1_p1_r}) - 58'(m1_p2_r);

  always_comb begin
    side2    = m1_side_r;
    side2.ok = m1_side_r.ok && !dr[57];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= v_i;
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_p1_r   <= p1;
      m1_p2_r   <= p2;
      m1_side_r <= side1;
      // D * R0 with 32 fraction bits appended, divided by R0 in the next chain
      m2_num_r  <= {dr[DR_W-1:0], 32'b0};
      m2_side_r <= side2;
    end
  end

  assign v_o    = m2_v_r;
  assign den_o  = cfg.r0;
  assign num_o  = m2_num_r;
  assign side_o = m2_side_r;

endmodule

@@ sv/rtc_back.sv @@
// Back stages: root to temperature by reciprocal division, offset, clamp, classes.
// Depends on rtc_pkg and rtc_out_if; drives the result channel register.
module rtc_back import rtc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  cfg_t            cfg,
  input  logic            v_i,
  input  logic [SQ_W-1:0] s_i,
  input  side_t           side_i,
  rtc_out_if.source       out_bus
);

  localparam logic signed [34:0] MLoS   = 35'(M_LO);
  localparam logic signed [34:0] MHiS   = 35'(M_HI);
  localparam logic [RECIP_W-1:0] RecipK = RECIP_W'(RECIP_K);
  localparam logic [13:0]        DivB   = 14'(CVD_B);
  localparam logic signed [19:0] TMax   = 20'(TEMP_MAX_CENTI);

  logic signed [33:0] x;
  logic signed [46:0] n;
  logic               b1_v_r;
  logic signed [46:0] b1_n_r;
  side_t              b1_side_r;

  logic signed [34:0] m, m_cl;
  logic               b2_v_r;
  logic [MP_W-1:0]    b2_mp_r;
  side_t              b2_side_r;

  logic               b3_v_r;
  logic [MP_W+RECIP_W-1:0] b3_prod_r;
  logic [MP_W-1:0]    b3_mp_r;
  side_t              b3_side_r;

  logic [QE_W-1:0]    qe;
  logic               b4_v_r;
  logic [QE_W-1:0]    b4_qe_r;
  logic [QE_W+13:0]   b4_pq_r;
  logic [MP_W-1:0]    b4_mp_r;
  side_t              b4_side_r;

  logic [MP_W-1:0]    rmd;
  logic [QE_W-1:0]    qf;
  logic signed [19:0] tq;
  logic [16:0]        temp;
  status_t            status;
  state_t             state;

  logic               out_v_r;
  logic [16:0]        temp_r;
  logic [31:0]        res_r;
  logic signed [22:0] suv_r;
  logic signed [25:0] buv_r;
  logic [2:0]         status_r, state_r;
  logic               conv_r;

  assign x = signed'(34'(CVD_A_Q16)) - signed'(34'(s_i));
  assign n = x * 47'(SCALE_MUL) + 47'(SCALE_BIAS);

  assign m = 35'(b1_n_r >>> SCALE_SHR);

  always_comb begin
    if (m < MLoS) begin
      m_cl = MLoS;
    end else if (m > MHiS) begin
      m_cl = MHiS;
    end else begin
      m_cl = m;
    end
  end

  // quotient estimate may be one short; fixed in the last stage
  assign qe = QE_W'(b3_prod_r >> RECIP_SHIFT);

  assign rmd = b4_mp_r - MP_W'(b4_pq_r);
  assign qf  = b4_qe_r + QE_W'(rmd >= MP_W'(DivB));
  assign tq  = signed'(20'(qf)) + 20'(Q_LO) + 20'(cfg.offset);

  always_comb begin
    if (!b4_side_r.ok) begin
      temp = '0;
    end else if (tq < 20'sd0) begin
      temp = '0;
    end else if (tq > TMax) begin
      temp = TMax[16:0];
    end else begin
      temp = tq[16:0];
    end
  end

  always_comb begin
    priority if (temp >= 17'(CLS_MODERATE) && temp <= 17'(CLS_WARNING)) begin
      status = STS_MODERATE;
      state  = SST_NORMAL;
    end else if (temp > 17'(CLS_WARNING) && temp < 17'(CLS_CRITICAL)) begin
      status = STS_WARNING;
      state  = SST_INCREASING;
    end else if (temp >= 17'(CLS_CRITICAL) && temp < 17'(CLS_HIGH)) begin
      status = STS_CRITICAL;
      state  = SST_CRITICAL;
    end else if (temp >= 17'(CLS_HIGH) && temp < 17'(CLS_VHIGH)) begin
      status = STS_HIGH;
      state  = SST_HIGH;
    end else if (temp >= 17'(CLS_VHIGH)) begin
      status = STS_VERY_HIGH;
      state  = SST_VERY_HIGH;
    end else begin
      status = STS_LOW;
      state  = SST_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      b2_v_r  <= 1'b0;
      b3_v_r  <= 1'b0;
      b4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      b1_v_r  <= v_i;
      b2_v_r  <= b1_v_r;
      b3_v_r  <= b2_v_r;
      b4_v_r  <= b3_v_r;
      out_v_r <= b4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_n_r    <= n;
      b1_side_r <= side_i;
      b2_mp_r   <= MP_W'(m_cl - MLoS);
      b2_side_r <= b1_side_r;
      b3_prod_r <= (MP_W+RECIP_W)'(b2_mp_r) * (MP_W+RECIP_W)'(RecipK);
      b3_mp_r   <= b2_mp_r;
      b3_side_r <= b2_side_r;
      b4_qe_r   <= qe;
      b4_pq_r   <= (QE_W+14)'(qe) * (QE_W+14)'(DivB);
      b4_mp_r   <= b3_mp_r;
      b4_side_r <= b3_side_r;
      temp_r    <= temp;
      res_r     <= b4_side_r.ok ? b4_side_r.rc : '0;
      suv_r     <= b4_side_r.suv;
      buv_r     <= b4_side_r.buv;
      status_r  <= status;
      state_r   <= state;
      conv_r    <= b4_side_r.ok;
    end
  end

  assign out_bus.valid               = out_v_r;
  assign out_bus.temperature_centi   = temp_r;
  assign out_bus.resistance_centiohm = res_r;
  assign out_bus.sensor_microvolts   = suv_r;
  assign out_bus.battery_microvolts  = buv_r;
  assign out_bus.status_code         = status_r;
  assign out_bus.state_code          = state_r;
  assign out_bus.conversion_valid    = conv_r;

endmodule

@@ sv/rtd_temperature_classifier.sv @@
// Top level of the RTD temperature classifier: configuration registers and cell chains.
// Depends on rtc_pkg, rtc_if, rtc_front, rtc_div_cell, rtc_mid, rtc_sqrt_cell, rtc_back.
//
// Usage:
//   in_bus carries one beat per sample: a sensor and a battery converter code.
//   out_bus returns one beat per sample, in order: temperature, resistance,
//   both voltages, status and state codes and the conversion flag.
//   cfg_we/cfg_index/cfg_wdata write one register per cycle; indexes above
//   four are dropped. Write only while no sample is in flight.
// Throughput: one sample per cycle, sustained while the receiver does not hold off.
// Pipeline from input beat to output beat: 4 front stages,
//   32 resistance division cells, 2 discriminant stages, 86 cells dividing
//   by the nominal resistance, 32 square root cells, 5 back stages.
// The whole pipeline moves as one; when the receiver holds off, the result
//   register keeps its beat and in_bus.ready drops in the same cycle.
// Reset clears all stage valid bits and loads the default configuration.
module rtd_temperature_classifier import rtc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rtc_in_if.sink      in_bus,
  rtc_out_if.source   out_bus,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [21:0] cfg_wdata
);

  localparam int NDIV2 = DR_NUM_W;

  cfg_t cfg_r;
  logic en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.supply <= 22'd3300000;
      cfg_r.rfix   <= 20'd10000;
      cfg_r.r0     <= 14'd1000;
      cfg_r.offset <= '0;
      cfg_r.bdiv   <= 5'd6;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SUPPLY: cfg_r.supply <= cfg_wdata;
        CFG_RFIX:   cfg_r.rfix   <= cfg_wdata[19:0];
        CFG_R0:     cfg_r.r0     <= cfg_wdata[R0_W-1:0];
        CFG_OFFSET: cfg_r.offset <= signed'(cfg_wdata[10:0]);
        CFG_BDIV:   cfg_r.bdiv   <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  assign en           = !out_bus.valid || out_bus.ready;
  assign in_bus.ready = en;

  // resistance division chain
  logic                 d1_v   [0:RES_Q_W];
  logic [RES_DEN_W-1:0] d1_den [0:RES_Q_W];
  logic [RES_DEN_W-1:0] d1_rem [0:RES_Q_W];
  logic [RES_Q_W-1:0]   d1_num [0:RES_Q_W];
  logic [RES_Q_W-1:0]   d1_q   [0:RES_Q_W];
  side_t                d1_side[0:RES_Q_W];

  rtc_front u_front (
    .clk, .rst_n, .en, .cfg(cfg_r),
    .v_i(in_bus.valid), .sensor_code(in_bus.sensor_code),
    .battery_code(in_bus.battery_code),
    .v_o(d1_v[0]), .den_o(d1_den[0]), .rem_o(d1_rem[0]),
    .num_o(d1_num[0]), .side_o(d1_side[0])
  );
  assign d1_q[0] = '0;

  for (genvar i = 0; i < RES_Q_W; i++) begin : g_div_res
    rtc_div_cell #(.DW(RES_DEN_W), .NW(RES_Q_W), .QW(RES_Q_W)) u_cell (
      .clk, .rst_n, .en,
      .v_i(d1_v[i]), .den_i(d1_den[i]), .rem_i(d1_rem[i]), .num_i(d1_num[i]),
      .q_i(d1_q[i]), .side_i(d1_side[i]),
      .v_o(d1_v[i+1]), .den_o(d1_den[i+1]), .rem_o(d1_rem[i+1]),
      .num_o(d1_num[i+1]), .q_o(d1_q[i+1]), .side_o(d1_side[i+1])
    );
  end

  // division of D * R0 by R0, fraction bits included
  logic                d2_v   [0:NDIV2];
  logic [R0_W-1:0]     d2_den [0:NDIV2];
  logic [R0_W-1:0]     d2_rem [0:NDIV2];
  logic [NDIV2-1:0]    d2_num [0:NDIV2];
  logic [SQ_IN_W-1:0]  d2_q   [0:NDIV2];
  side_t               d2_side[0:NDIV2];

  rtc_mid u_mid (
    .clk, .rst_n, .en, .cfg(cfg_r),
    .v_i(d1_v[RES_Q_W]), .q_i(d1_q[RES_Q_W]), .side_i(d1_side[RES_Q_W]),
    .v_o(d2_v[0]), .den_o(d2_den[0]), .num_o(d2_num[0]), .side_o(d2_side[0])
  );
  assign d2_rem[0] = '0;
  assign d2_q[0]   = '0;

  for (genvar i = 0; i < NDIV2; i++) begin : g_div_disc
    rtc_div_cell #(.DW(R0_W), .NW(NDIV2), .QW(SQ_IN_W)) u_cell (
      .clk, .rst_n, .en,
      .v_i(d2_v[i]), .den_i(d2_den[i]), .rem_i(d2_rem[i]), .num_i(d2_num[i]),
      .q_i(d2_q[i]), .side_i(d2_side[i]),
      .v_o(d2_v[i+1]), .den_o(d2_den[i+1]), .rem_o(d2_rem[i+1]),
      .num_o(d2_num[i+1]), .q_o(d2_q[i+1]), .side_o(d2_side[i+1])
    );
  end

  // square root chain
  logic               sq_v   [0:SQ_W];
  logic [SQ_IN_W-1:0] sq_rad [0:SQ_W];
  logic [SQ_W:0]      sq_rem [0:SQ_W];
  logic [SQ_W-1:0]    sq_root[0:SQ_W];
  side_t              sq_side[0:SQ_W];

  assign sq_v[0]    = d2_v[NDIV2];
  assign sq_rad[0]  = d2_q[NDIV2];
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = d2_side[NDIV2];

  for (genvar i = 0; i < SQ_W; i++) begin : g_sqrt
    rtc_sqrt_cell #(.RW(SQ_W)) u_cell (
      .clk, .rst_n, .en,
      .v_i(sq_v[i]), .rad_i(sq_rad[i]), .rem_i(sq_rem[i]), .root_i(sq_root[i]),
      .side_i(sq_side[i]),
      .v_o(sq_v[i+1]), .rad_o(sq_rad[i+1]), .rem_o(sq_rem[i+1]),
      .root_o(sq_root[i+1]), .side_o(sq_side[i+1])
    );
  end

  rtc_back u_back (
    .clk, .rst_n, .en, .cfg(cfg_r),
    .v_i(sq_v[SQ_W]), .s_i(sq_root[SQ_W]), .side_i(sq_side[SQ_W]),
    .out_bus
  );

  // failed conversions report zero temperature and resistance
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && !out_bus.conversion_valid |->
      out_bus.temperature_centi == '0 && out_bus.resistance_centiohm == '0)
    else $error("invalid conversion with non-zero result");

  a_temp_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> out_bus.temperature_centi <= 17'(TEMP_MAX_CENTI))
    else $error("temperature above limit");

  a_class_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |->
      (out_bus.status_code == STS_LOW && out_bus.state_code == SST_NORMAL) ||
      (out_bus.status_code == STS_MODERATE && out_bus.state_code == SST_NORMAL) ||
      (out_bus.status_code == STS_WARNING && out_bus.state_code == SST_INCREASING) ||
      (out_bus.status_code == STS_CRITICAL && out_bus.state_code == SST_CRITICAL) ||
      (out_bus.status_code == STS_HIGH && out_bus.state_code == SST_HIGH) ||
      (out_bus.status_code == STS_VERY_HIGH && out_bus.state_code == SST_VERY_HIGH))
    else $error("status and state codes disagree");

  a_valid_voltage: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.conversion_valid |->
      out_bus.sensor_microvolts > 23'sd10000)
    else $error("valid conversion from out-of-range voltage");

  a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && !out_bus.ready |=> out_bus.valid)
    else $error("result beat lost under stall");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench of rtd_temperature_classifier: directed table, then random phases.
// Depends on rtc_pkg, rtc_if and the block itself.
`timescale 1ns / 100ps

module tb_top;
  import rtc_pkg::*;

  typedef struct {
    logic [16:0]        temp;
    logic [31:0]        res;
    logic signed [22:0] suv;
    logic signed [25:0] buv;
    status_t            status;
    state_t             st;
    logic               ok;
  } reading_t;

  typedef struct {
    logic signed [15:0] sensor;
    logic signed [15:0] battery;
    bit                 typed;     // known invalid conversion
  } row_t;

  logic clk;
  logic rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [21:0] cfg_wdata;

  rtc_in_if  in_ch ();
  rtc_out_if out_ch ();

  rtd_temperature_classifier u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_ch),
    .out_bus  (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  cfg_t     shadow;
  reading_t expected_q[$];
  int       errors = 0;
  bit       no_gaps = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic reading_t convert(logic signed [15:0] sc, logic signed [15:0] bc);
    reading_t o;
    longint suv, buv, t, den, r0, dr, s, n, d;
    logic [63:0] num, rc, q;
    suv = longint'(sc) * ADC_FULL_SCALE_MV * 1000 / 32768;
    buv = (longint'(bc) * ADC_FULL_SCALE_MV * 1000 / 32768) * longint'(shadow.bdiv);
    t = 0;
    o.res = 0;
    o.ok = 0;
    r0 = longint'(shadow.r0);
    if (sc > 0 && suv > MIN_SENSOR_UV && suv < longint'(shadow.supply) && r0 != 0) begin
      den = longint'(shadow.supply) - suv;
      num = 64'(suv) * 64'(shadow.rfix) * 64'd100;
      rc = (num + 64'(den / 2)) / 64'(den);
      if (rc > 64'hFFFF_FFFF) rc = 64'hFFFF_FFFF;
      dr = CVD_A * CVD_A * r0 - 400 * CVD_B * (longint'(rc) - 100 * r0);
      if (dr >= 0) begin
        q = (64'(dr / r0) << 32) + ((64'(dr % r0) << 32) / 64'(r0));
        s = longint'(isqrt(q));
        n = (CVD_A * 65536 - s) * 100000;
        d = 2 * CVD_B * 65536;
        t = floor_div(2 * n + d, 2 * d) + longint'(shadow.offset);
        o.res = rc[31:0];
        o.ok = 1;
      end
    end
    if (t < 0) t = 0;
    if (t > TEMP_MAX_CENTI) t = TEMP_MAX_CENTI;
    o.temp = 17'(t);
    if (t >= CLS_MODERATE && t <= CLS_WARNING) begin
      o.status = STS_MODERATE;  o.st = SST_NORMAL;
    end else if (t > CLS_WARNING && t < CLS_CRITICAL) begin
      o.status = STS_WARNING;   o.st = SST_INCREASING;
    end else if (t >= CLS_CRITICAL && t < CLS_HIGH) begin
      o.status = STS_CRITICAL;  o.st = SST_CRITICAL;
    end else if (t >= CLS_HIGH && t < CLS_VHIGH) begin
      o.status = STS_HIGH;      o.st = SST_HIGH;
    end else if (t >= CLS_VHIGH) begin
      o.status = STS_VERY_HIGH; o.st = SST_VERY_HIGH;
    end else begin
      o.status = STS_LOW;       o.st = SST_NORMAL;
    end
    if (suv < -(longint'(1) << 22)) suv = -(longint'(1) << 22);
    if (suv > (longint'(1) << 22) - 1) suv = (longint'(1) << 22) - 1;
    if (buv < -(longint'(1) << 25)) buv = -(longint'(1) << 25);
    if (buv > (longint'(1) << 25) - 1) buv = (longint'(1) << 25) - 1;
    o.suv = 23'(suv);
    o.buv = 26'(buv);
    return o;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [21:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_SUPPLY: shadow.supply = val;
      CFG_RFIX:   shadow.rfix   = val[19:0];
      CFG_R0:     shadow.r0     = val[R0_W-1:0];
      CFG_OFFSET: shadow.offset = val[10:0];
      CFG_BDIV:   shadow.bdiv   = val[4:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [21:0] sup, logic [21:0] rf, logic [21:0] r0,
                           logic [21:0] off, logic [21:0] bd);
    write_reg(CFG_SUPPLY, sup);
    write_reg(CFG_RFIX, rf);
    write_reg(CFG_R0, r0);
    write_reg(CFG_OFFSET, off);
    write_reg(CFG_BDIV, bd);
  endtask

  // an index past the last register must leave everything alone
  task automatic write_stray();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= 3'($urandom_range(5, 7));
    cfg_wdata <= 22'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // valid stays high into the next beat when there is no gap
  task automatic send_sample(logic signed [15:0] sc, logic signed [15:0] bc, reading_t exp);
    bit fire;
    int g;
    g = gap_len();
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sensor_code  <= sc;
    in_ch.battery_code <= bc;
    do begin
      @(negedge clk);
      fire = in_ch.ready;
      @(posedge clk);
    end while (!fire);
    expected_q.push_back(exp);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // sensor code aimed at a resistance between 0.8 and 4 times nominal
  function automatic logic signed [15:0] aimed_code();
    longint rr, v;
    rr = longint'(shadow.r0) * $urandom_range(80, 400) / 100;
    v = longint'(shadow.supply) * rr / (rr + longint'(shadow.rfix) + 1) / 125;
    if (v < 1) v = 1;
    if (v > 32767) v = 32767;
    return 16'(v);
  endfunction

  task automatic random_sample();
    logic signed [15:0] sc;
    logic signed [15:0] bc;
    int  pick;
    longint top;
    pick = $urandom_range(0, 99);
    top = longint'(shadow.supply) / 125;
    if (top > 32767) top = 32767;
    if (top < 81) top = 81;
    if (pick < 60) sc = aimed_code();
    else if (pick < 75) sc = 16'($urandom_range(81, top));
    else sc = 16'($urandom);
    bc = 16'($urandom);
    send_sample(sc, bc, convert(sc, bc));
  endtask

  // output receiver: ready with random holds
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      int g;
      out_ch.ready <= 1'b1;
      @(posedge clk);
      g = gap_len();
      if (g != 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  // results are compared on the falling edge, ahead of the beat at the next rising edge
  always @(negedge clk) begin
    reading_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat", $time);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_ch.temperature_centi !== e.temp) begin
          $display("%0t: temperature exp %0d act %0d", $time, e.temp,
                   out_ch.temperature_centi);
          errors++;
        end
        if (out_ch.resistance_centiohm !== e.res) begin
          $display("%0t: resistance exp %0d act %0d", $time, e.res,
                   out_ch.resistance_centiohm);
          errors++;
        end
        if (out_ch.sensor_microvolts !== e.suv) begin
          $display("%0t: sensor uV exp %0d act %0d", $time, e.suv, out_ch.sensor_microvolts);
          errors++;
        end
        if (out_ch.battery_microvolts !== e.buv) begin
          $display("%0t: battery uV exp %0d act %0d", $time, e.buv, out_ch.battery_microvolts);
          errors++;
        end
        if (out_ch.status_code !== e.status) begin
          $display("%0t: status exp %0d act %0d", $time, e.status, out_ch.status_code);
          errors++;
        end
        if (out_ch.state_code !== e.st) begin
          $display("%0t: state exp %0d act %0d", $time, e.st, out_ch.state_code);
          errors++;
        end
        if (out_ch.conversion_valid !== e.ok) begin
          $display("%0t: valid flag exp %0d act %0d", $time, e.ok, out_ch.conversion_valid);
          errors++;
        end
      end
    end
  end

  initial begin
    row_t     rows[$];
    reading_t e;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_SUPPLY;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.sensor_code  <= '0;
    in_ch.battery_code <= '0;
    shadow = '{supply: 22'd3300000, rfix: 20'd10000, r0: 14'd1000, offset: 11'sd0, bdiv: 5'd6};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // defaults after reset: 125 uV per code, 3.3 V supply
    rows = '{
      '{-16'sd32768, -16'sd32768, 1}, '{16'sd0, 16'sd0, 1}, '{16'sd32767, 16'sd32767, 1},
      '{-16'sd1, 16'sd1, 1}, '{16'sd80, 16'sd100, 1}, '{16'sd26400, 16'sd26400, 1},
      '{16'sd81, -16'sd1, 0}, '{16'sd26399, 16'sd5000, 0}, '{16'sd2400, 16'sd8000, 0},
      '{16'sd2700, 16'sd9000, 0}, '{16'sd2800, 16'sd10000, 0}, '{16'sd2900, 16'sd11000, 0},
      '{16'sd3000, 16'sd12000, 0}, '{16'sd3100, 16'sd13000, 0}, '{16'sd3200, 16'sd14000, 0},
      '{16'sd3500, 16'sd15000, 0}, '{16'sd4000, 16'sd16000, 0}, '{16'sd5000, 16'sd20000, 0},
      '{16'sd7000, 16'sd24000, 0}, '{16'sd9000, 16'sd30000, 0}, '{16'sd20000, -16'sd20000, 0}
    };
    foreach (rows[i]) begin
      e = convert(rows[i].sensor, rows[i].battery);
      if (rows[i].typed) begin
        e.temp = 0; e.res = 0; e.ok = 0; e.status = STS_LOW; e.st = SST_NORMAL;
      end
      send_sample(rows[i].sensor, rows[i].battery, e);
    end
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: ;
        1: write_all(22'd1000000, 22'd100, 22'd100, 22'(-11'sd1000), 22'd1);
        2: write_all(22'd4096000, 22'd1000000, 22'd10000, 22'd1000, 22'd16);
        3: write_all(22'h3FFFFF, 22'hFFFFF, 22'h3FFF, 22'h3FF, 22'd31);
        4: write_all(22'd3300000, 22'd10000, 22'd0, 22'h400, 22'd0);
        default: write_all(22'($urandom_range(1000000, 4194303)),
                           22'($urandom_range(100, 1048575)),
                           22'($urandom_range(1, 16383)),
                           22'($urandom_range(0, 2047)), 22'($urandom_range(0, 31)));
      endcase
      if (ph % 2 == 1) write_stray();
      for (int k = 0; k < 66; k++) begin
        no_gaps = (k >= 20 && k < 35);
        random_sample();
      end
      no_gaps = 0;
      drain();
    end

    repeat (200) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
